### sv/dvr_pkg.sv
// ---------------------------------------------------------------------------
// Distance-vector route update package
// Shared widths, request codes, register indexes and table port structs.
// ---------------------------------------------------------------------------
package dvr_pkg;

    // Fixed field widths.
    localparam int NODE_W    = 3;
    localparam int COST_W    = 8;
    localparam int FUNC_W    = 2;
    localparam int LINK_W    = 64;
    localparam int DEAD_W    = 8;
    localparam int CFG_IDX_W = 1;

    // Request kinds.
    typedef enum logic [FUNC_W-1:0] {
        FN_INIT   = 2'd0,
        FN_VECTOR = 2'd1,
        FN_TICK   = 2'd2,
        FN_LOOKUP = 2'd3
    } func_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SELF_ID    = 1'b0,
        REG_LINK_COSTS = 1'b1
    } cfg_reg_t;

    // One next-hop table entry.
    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] hop;
    } hop_entry_t;

    // Write commands from the sequencer to the route tables.
    typedef struct packed {
        logic              own_we;
        logic              nb_we;
        logic              hop_we;
        logic [NODE_W-1:0] waddr;
        logic [COST_W-1:0] own_wdata;
        logic [COST_W-1:0] nb_wdata;
        hop_entry_t        hop_wdata;
        logic              alive_set;
        logic [NODE_W-1:0] alive_node;
        logic              alive_clr;
    } tab_wr_t;

    // Read data of the route tables at one address.
    typedef struct packed {
        logic [COST_W-1:0] own;
        logic [COST_W-1:0] nb;
        hop_entry_t        hop;
        logic              alive;
    } tab_rd_t;

endpackage

### sv/dvr_alu.sv
// ---------------------------------------------------------------------------
// Distance-vector shared cost unit
// Adds two costs, saturates the sum at infinity and compares it to a bound.
// ---------------------------------------------------------------------------
module dvr_alu #(
    parameter int INF_COST = 255
) (
    input  logic [dvr_pkg::COST_W-1:0] a,
    input  logic [dvr_pkg::COST_W-1:0] b,
    input  logic [dvr_pkg::COST_W-1:0] bound,
    output logic [dvr_pkg::COST_W-1:0] sum_sat,
    output logic                       over,
    output logic                       below
);
    import dvr_pkg::*;

    localparam logic [COST_W:0] INF_EXT = (COST_W+1)'(INF_COST);

    logic [COST_W:0] sum;

    // Nine-bit sum so that no carry is lost.
    assign sum = {1'b0, a} + {1'b0, b};

    // Saturation at infinity and the compare against the bound.
    assign over    = (sum > INF_EXT);
    assign sum_sat = over ? INF_EXT[COST_W-1:0] : sum[COST_W-1:0];
    assign below   = (sum < {1'b0, bound});

endmodule

### sv/dvr_rtab.sv
// ---------------------------------------------------------------------------
// Distance-vector route tables
// Own cost, neighbor cost and next-hop register files with alive marks.
// ---------------------------------------------------------------------------
module dvr_rtab #(
    parameter int NODES    = 8,
    parameter int INF_COST = 255
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [dvr_pkg::NODE_W-1:0] rd_addr,
    input  dvr_pkg::tab_wr_t           wr,
    output dvr_pkg::tab_rd_t           rd
);
    import dvr_pkg::*;

    localparam int IDX_W = $clog2(NODES);
    localparam logic [COST_W-1:0] INF = COST_W'(INF_COST);

    logic [COST_W-1:0] own_reg [NODES];
    logic [COST_W-1:0] nb_reg  [NODES];
    hop_entry_t        hop_reg [NODES];
    logic [NODES-1:0]  alive_reg;
    logic [IDX_W-1:0]  ridx;
    logic [IDX_W-1:0]  widx;
    logic [IDX_W-1:0]  aidx;

    assign ridx = rd_addr[IDX_W-1:0];
    assign widx = wr.waddr[IDX_W-1:0];
    assign aidx = wr.alive_node[IDX_W-1:0];

    // Single read port shared by all tables.
    assign rd.own   = own_reg[ridx];
    assign rd.nb    = nb_reg[ridx];
    assign rd.hop   = hop_reg[ridx];
    assign rd.alive = alive_reg[ridx];

    // Table writes; reset puts every cost at infinity and every hop invalid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                own_reg[i] <= INF;
                nb_reg[i]  <= INF;
                hop_reg[i] <= '0;
            end
            alive_reg <= '0;
        end
        else
        begin
            if (wr.own_we)
            begin
                own_reg[widx] <= wr.own_wdata;
            end
            if (wr.nb_we)
            begin
                nb_reg[widx] <= wr.nb_wdata;
            end
            if (wr.hop_we)
            begin
                hop_reg[widx] <= wr.hop_wdata;
            end
            if (wr.alive_clr)
            begin
                alive_reg <= '0;
            end
            else if (wr.alive_set)
            begin
                alive_reg[aidx] <= 1'b1;
            end
        end
    end

endmodule

### sv/distance_vector_route_update_top.sv
// ---------------------------------------------------------------------------
// Distance-vector route update
// Keeps one node's routing table and applies init, vector, tick and lookup
// requests one at a time through a shared cost unit.
// ---------------------------------------------------------------------------
// One request is worked at a time; in_ready is high only while the sequencer
// is idle. A lookup or an ignored vector entry goes straight to the result
// step; a vector entry first reads the destination entry, then relaxes it
// through the source. An init walks every node entry, and so does a liveness
// tick, which then reloads the own-cost table entry by entry when a neighbor
// is declared down. The walks are paced by the single table read port and
// the one shared add-and-compare unit, which visit one node entry per cycle.
// An output register holds the result until it is taken; a new request may
// be accepted meanwhile, and its result waits for the register.
// There is no clearing pass after reset.
module distance_vector_route_update_top #(
    parameter int NODES    = 8,
    parameter int INF_COST = 255
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [dvr_pkg::FUNC_W-1:0]    func,
    input  logic [dvr_pkg::NODE_W-1:0]    source_node,
    input  logic [dvr_pkg::NODE_W-1:0]    dest_node,
    input  logic [dvr_pkg::COST_W-1:0]    adv_cost,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dvr_pkg::COST_W-1:0]    route_cost,
    output logic [dvr_pkg::NODE_W-1:0]    next_hop,
    output logic                          hop_valid,
    output logic                          table_changed,
    output logic [dvr_pkg::DEAD_W-1:0]    dead_mask,
    input  logic                          cfg_wr_en,
    input  logic [dvr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dvr_pkg::LINK_W-1:0]    cfg_wdata
);
    import dvr_pkg::*;

    localparam int IDX_W = $clog2(NODES);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NODES - 1);
    localparam logic [COST_W-1:0] INF       = COST_W'(INF_COST);
    localparam logic [NODE_W:0]   NODES_EXT = (NODE_W+1)'(NODES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_VEC_D,
        S_VEC_S,
        S_TICK,
        S_RELOAD,
        S_RESULT
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    logic [NODE_W-1:0]  src_reg, src_next;
    logic [NODE_W-1:0]  dst_reg, dst_next;
    logic [COST_W-1:0]  adv_reg, adv_next;
    logic [COST_W-1:0]  own_d_reg, own_d_next;
    logic               poison_reg, poison_next;
    logic               changed_reg, changed_next;
    logic [NODES-1:0]   dead_reg, dead_next;
    logic [NODE_W-1:0]  self_id_reg;
    logic [LINK_W-1:0]  link_costs_reg;
    logic               out_valid_reg, out_valid_next;
    logic [COST_W-1:0]  route_cost_reg, route_cost_next;
    logic [NODE_W-1:0]  next_hop_reg, next_hop_next;
    logic               hop_valid_reg, hop_valid_next;
    logic               table_changed_reg, table_changed_next;
    logic [DEAD_W-1:0]  dead_mask_reg, dead_mask_next;

    tab_wr_t            tab_wr;
    tab_rd_t            tab_rd;
    logic [NODE_W-1:0]  rd_addr;
    logic [COST_W-1:0]  alu_a, alu_b, alu_bound, alu_sum;
    logic               alu_over, alu_below;

    logic [NODE_W-1:0]  cnt_node;
    logic               cnt_last;
    logic [COST_W-1:0]  link_byte;
    logic               src_ok, dst_ok, dst_reg_ok;
    logic               is_self, init_hop_ok;
    logic               poison, relax, node_down;
    logic [COST_W-1:0]  own_s_eff;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_id_reg    <= '0;
            link_costs_reg <= '1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SELF_ID:    self_id_reg    <= cfg_wdata[NODE_W-1:0];
                REG_LINK_COSTS: link_costs_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // Route tables and the shared cost unit.
    dvr_rtab #(
        .NODES    (NODES),
        .INF_COST (INF_COST)
    ) u_rtab (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .wr      (tab_wr),
        .rd      (tab_rd)
    );

    dvr_alu #(
        .INF_COST (INF_COST)
    ) u_alu (
        .a       (alu_a),
        .b       (alu_b),
        .bound   (alu_bound),
        .sum_sat (alu_sum),
        .over    (alu_over),
        .below   (alu_below)
    );

    // Helper terms for the sequencer.
    assign cnt_node   = NODE_W'(cnt_reg);
    assign cnt_last   = (cnt_reg == LAST_IDX);
    assign link_byte  = link_costs_reg[COST_W*cnt_reg +: COST_W];
    assign src_ok     = ({1'b0, source_node} < NODES_EXT);
    assign dst_ok     = ({1'b0, dest_node} < NODES_EXT);
    assign dst_reg_ok = ({1'b0, dst_reg} < NODES_EXT);
    assign is_self    = (cnt_node == self_id_reg);
    assign init_hop_ok = is_self || alu_below;
    assign poison     = (adv_reg == INF) && tab_rd.hop.valid && (tab_rd.hop.hop == src_reg);
    assign own_s_eff  = (poison_reg && (src_reg == dst_reg)) ? INF : tab_rd.own;
    assign relax      = alu_below && !alu_over;
    assign node_down  = !tab_rd.alive && !is_self && alu_below;

    // Sequencer: walks the table entries and drives the shared unit.
    always_comb
    begin
        state_next         = state_reg;
        cnt_next           = cnt_reg;
        src_next           = src_reg;
        dst_next           = dst_reg;
        adv_next           = adv_reg;
        own_d_next         = own_d_reg;
        poison_next        = poison_reg;
        changed_next       = changed_reg;
        dead_next          = dead_reg;
        out_valid_next     = out_valid_reg;
        route_cost_next    = route_cost_reg;
        next_hop_next      = next_hop_reg;
        hop_valid_next     = hop_valid_reg;
        table_changed_next = table_changed_reg;
        dead_mask_next     = dead_mask_reg;
        tab_wr             = '0;
        rd_addr            = dst_reg;
        alu_a              = '0;
        alu_b              = '0;
        alu_bound          = INF;

        // The result register empties when the consumer takes it.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    src_next     = source_node;
                    dst_next     = dest_node;
                    adv_next     = (adv_cost > INF) ? INF : adv_cost;
                    changed_next = 1'b0;
                    poison_next  = 1'b0;
                    dead_next    = '0;
                    cnt_next     = '0;
                    unique case (func_t'(func))
                        FN_INIT:   state_next = S_INIT;
                        FN_VECTOR: state_next = (src_ok && dst_ok) ? S_VEC_D : S_RESULT;
                        FN_TICK:   state_next = S_TICK;
                        FN_LOOKUP: state_next = S_RESULT;
                        default:   state_next = S_RESULT;
                    endcase
                end
            end

            // Load one entry per cycle from the link-cost register.
            S_INIT:
            begin
                alu_a                  = link_byte;
                tab_wr.own_we          = 1'b1;
                tab_wr.nb_we           = 1'b1;
                tab_wr.hop_we          = 1'b1;
                tab_wr.waddr           = cnt_node;
                tab_wr.own_wdata       = is_self ? '0 : alu_sum;
                tab_wr.nb_wdata        = is_self ? '0 : alu_sum;
                tab_wr.hop_wdata.valid = init_hop_ok;
                tab_wr.hop_wdata.hop   = init_hop_ok ? cnt_node : '0;
                changed_next           = 1'b1;
                if (cnt_last)
                begin
                    tab_wr.alive_clr = 1'b1;
                    state_next       = S_RESULT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // Read the destination entry and decide on poisoning.
            S_VEC_D:
            begin
                rd_addr     = dst_reg;
                poison_next = poison;
                own_d_next  = poison ? INF : tab_rd.own;
                state_next  = S_VEC_S;
            end

            // Relax through the source and write the destination entry.
            S_VEC_S:
            begin
                rd_addr                = src_reg;
                alu_a                  = adv_reg;
                alu_b                  = own_s_eff;
                alu_bound              = own_d_reg;
                tab_wr.own_we          = relax || poison_reg;
                tab_wr.hop_we          = relax || poison_reg;
                tab_wr.waddr           = dst_reg;
                tab_wr.own_wdata       = relax ? alu_sum : INF;
                tab_wr.hop_wdata.valid = relax;
                tab_wr.hop_wdata.hop   = relax ? src_reg : '0;
                tab_wr.alive_set       = 1'b1;
                tab_wr.alive_node      = src_reg;
                changed_next           = relax || poison_reg;
                state_next             = S_RESULT;
            end

            // Check one neighbor per cycle for silence.
            S_TICK:
            begin
                rd_addr = cnt_node;
                alu_a   = tab_rd.nb;
                if (node_down)
                begin
                    tab_wr.nb_we      = 1'b1;
                    tab_wr.hop_we     = 1'b1;
                    tab_wr.waddr      = cnt_node;
                    tab_wr.nb_wdata   = INF;
                    tab_wr.hop_wdata  = '0;
                    dead_next[cnt_reg] = 1'b1;
                end
                if (cnt_last)
                begin
                    tab_wr.alive_clr = 1'b1;
                    cnt_next         = '0;
                    if ((dead_reg != '0) || node_down)
                    begin
                        changed_next = 1'b1;
                        state_next   = S_RELOAD;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // Copy neighbor costs into own costs after a neighbor went down.
            S_RELOAD:
            begin
                rd_addr          = cnt_node;
                tab_wr.own_we    = 1'b1;
                tab_wr.waddr     = cnt_node;
                tab_wr.own_wdata = tab_rd.nb;
                if (cnt_last)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // Report the destination entry once the result register is free.
            S_RESULT:
            begin
                rd_addr = dst_reg;
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next     = 1'b1;
                    route_cost_next    = dst_reg_ok ? tab_rd.own : INF;
                    hop_valid_next     = dst_reg_ok && tab_rd.hop.valid;
                    next_hop_next      = (dst_reg_ok && tab_rd.hop.valid) ? tab_rd.hop.hop : '0;
                    table_changed_next = changed_reg;
                    dead_mask_next     = DEAD_W'(dead_reg);
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            poison_reg    <= 1'b0;
            changed_reg   <= 1'b0;
            dead_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            poison_reg    <= poison_next;
            changed_reg   <= changed_next;
            dead_reg      <= dead_next;
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        src_reg           <= src_next;
        dst_reg           <= dst_next;
        adv_reg           <= adv_next;
        own_d_reg         <= own_d_next;
        route_cost_reg    <= route_cost_next;
        next_hop_reg      <= next_hop_next;
        hop_valid_reg     <= hop_valid_next;
        table_changed_reg <= table_changed_next;
        dead_mask_reg     <= dead_mask_next;
    end

    // Port drivers.
    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign route_cost    = route_cost_reg;
    assign next_hop      = next_hop_reg;
    assign hop_valid     = hop_valid_reg;
    assign table_changed = table_changed_reg;
    assign dead_mask     = dead_mask_reg;

endmodule

### sv/dvr_checker.sv
// ---------------------------------------------------------------------------
// Distance-vector route update checker
// Port-level assertions on the request and result channels, bound to the top.
// ---------------------------------------------------------------------------
module dvr_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [dvr_pkg::COST_W-1:0] route_cost,
    input logic [dvr_pkg::NODE_W-1:0] next_hop,
    input logic                       hop_valid,
    input logic                       table_changed,
    input logic [dvr_pkg::DEAD_W-1:0] dead_mask
);

    // A request keeps the block busy for at least the following cycle.
    property p_busy_after_accept;
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready;
    endproperty
    a_busy_after_accept: assert property (p_busy_after_accept)
        else $error("in_ready stayed high after a request was accepted");

    // A stalled result holds its payload.
    property p_result_holds;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(route_cost) && $stable(next_hop) &&
             $stable(hop_valid) && $stable(table_changed) && $stable(dead_mask));
    endproperty
    a_result_holds: assert property (p_result_holds)
        else $error("stalled result changed");

    // Without a known hop the reported hop is zero.
    property p_hop_zero;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !hop_valid) |-> (next_hop == '0);
    endproperty
    a_hop_zero: assert property (p_hop_zero)
        else $error("next_hop set while hop_valid is low");

    // Declaring a neighbor down always changes the table.
    property p_dead_changes;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && (dead_mask != '0)) |-> table_changed;
    endproperty
    a_dead_changes: assert property (p_dead_changes)
        else $error("dead_mask set without table_changed");

endmodule

bind distance_vector_route_update_top dvr_checker u_dvr_checker (.*);
